/* sv/fixed_block_free_list_allocator_macros.svh */
// ----------------------------------------------------------------------------
// fixed block free list allocator assertion macros
// shared property shorthands, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FBFL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FBFL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/fbfl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_pkg
// widths, codes and item types shared by the free list allocator
// ----------------------------------------------------------------------------
package fbfl_pkg;

    // fixed field widths
    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 17;
    localparam int TOTAL_W   = 7;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 2;

    // largest block count the total register can express
    localparam int TOTAL_MAX = 127;

    // register reset values and limits
    localparam int MIN_BLOCK_BYTES = 8;
    localparam int RST_BLOCK_BYTES = 64;
    localparam int RST_BLOCK_TOTAL = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_TOTAL  = 2'd2;

    typedef enum logic {
        FN_ALLOC   = 1'b0,
        FN_RELEASE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_OWNED = 2'd2
    } status_t;

    typedef struct packed {
        func_t             func;
        logic [ADDR_W-1:0] release_address;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] block_address;
        logic [CNT_W-1:0]  blocks_in_use;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [ADDR_W-1:0]    value;
    } cfg_t;

endpackage
`default_nettype wire

/* sv/fbfl_chan_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_chan_if
// valid/ready channel carrying one item of a given payload type
// ----------------------------------------------------------------------------
interface fbfl_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface
`default_nettype wire

/* sv/fbfl_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_div_cell
// one restoring division step: tries to take block size shifted left by
// SHIFT from the running offset and sets that quotient bit
// ----------------------------------------------------------------------------
module fbfl_div_cell #(
    parameter int SHIFT = 0,
    parameter int QUO_W = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_vld,
    input  wire logic [fbfl_pkg::ADDR_W-1:0] in_rem,
    input  wire logic [QUO_W-1:0]           in_quo,
    input  wire logic [fbfl_pkg::SIZE_W-1:0] size,
    output logic                            out_vld,
    output logic [fbfl_pkg::ADDR_W-1:0]     out_rem,
    output logic [QUO_W-1:0]                out_quo
);

    import fbfl_pkg::*;

    logic [ADDR_W-1:0] divisor;
    logic              take;
    logic              vld_reg;
    logic [ADDR_W-1:0] rem_reg;
    logic [QUO_W-1:0]  quo_reg;

    // shifted divisor and compare
    assign divisor = ADDR_W'(size) << SHIFT;
    assign take    = (in_rem >= divisor);

    // token that marks a live item in this cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    // partial remainder and quotient handed to the next cell
    always_ff @(posedge clk)
    begin
        rem_reg <= take ? (in_rem - divisor) : in_rem;
        quo_reg <= in_quo | (take ? (QUO_W'(1) << SHIFT) : '0);
    end

    assign out_vld = vld_reg;
    assign out_rem = rem_reg;
    assign out_quo = quo_reg;

endmodule
`default_nettype wire

/* sv/fbfl_free_list.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_free_list
// next-index memory of the free list with one valid bit per entry; an entry
// never written since the last clear reads as its own index plus one
// ----------------------------------------------------------------------------
module fbfl_free_list #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6,
    parameter int NXT_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire logic [IDX_W-1:0] rd_idx,
    output logic [NXT_W-1:0]      rd_next,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire logic [NXT_W-1:0] wr_data
);

    logic [NXT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [NXT_W-1:0] rd_mem_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_mem_reg <= mem[rd_idx];
        rd_idx_reg <= rd_idx;
    end

    // per-entry valid bits, cleared on reset and on rebuild
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_idx];
            if (clear)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // unwritten entries hold the ascending order
    assign rd_next = rd_vld_reg ? rd_mem_reg : (NXT_W'(rd_idx_reg) + NXT_W'(1));

endmodule
`default_nettype wire

/* sv/fixed_block_free_list_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_block_free_list_allocator_macros.svh"
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// hands out and takes back equal-sized blocks of a pool kept as a lifo list
//
// req carries one item: func (allocate or release) and release_address.
// rsp returns one item per request: status, block_address (zero unless an
// allocate succeeds) and blocks_in_use after the item.
// cfg writes base_address (0), block_bytes (1) or block_total (2); a write
// is dropped while any block is allocated, and a taken write rebuilds the
// free list in ascending order.
// one item is worked at a time. allocate: the result waits on the
// registered read of the next-index memory. release: the
// block index comes out of a chain of one division cell per index bit,
// each cell registered, and the quotient is registered before the result.
// the result sits in an output register; the next item is accepted while
// it waits, and only the update of the following result stalls on it.
// reset empties the pool usage, restores the ascending list through the
// per-entry valid bits at once, and sets the registers to 0, 64 and 64.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
    parameter int MAX_BLOCKS = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fbfl_chan_if.sink   req,
    fbfl_chan_if.source rsp,
    fbfl_chan_if.sink   cfg
);

    import fbfl_pkg::*;

    localparam int EFF_MAX   = (MAX_BLOCKS < TOTAL_MAX) ? MAX_BLOCKS : TOTAL_MAX;
    localparam int IDX_W     = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
    localparam int NXT_W     = $clog2(EFF_MAX + 1);
    localparam int POOL_W    = SIZE_W + NXT_W;
    localparam int PROD_W    = SIZE_W + IDX_W;
    localparam int RST_TOTAL = (EFF_MAX < RST_BLOCK_TOTAL) ? EFF_MAX : RST_BLOCK_TOTAL;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [NXT_W-1:0]  total_reg;
    logic [NXT_W-1:0]  head_reg;
    logic [CNT_W-1:0]  used_reg;
    logic              out_vld_reg;
    rsp_t              out_reg;

    func_t             func_reg;
    logic [ADDR_W-1:0] offset_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [POOL_W-1:0] pool_reg;
    logic [IDX_W-1:0]  quo_reg;
    logic              remz_reg;

    logic              req_acc;
    logic              cfg_acc;
    logic              cfg_known;
    logic              cfg_hit;
    logic [SIZE_W-1:0] wr_size;
    logic [SIZE_W-1:0] size_eff;
    logic [TOTAL_W-1:0] wr_total;
    logic [NXT_W-1:0]  total_eff;
    logic [ADDR_W-1:0] offset_in;

    logic              load_out;
    logic              is_alloc;
    logic              alloc_empty;
    logic              rel_owned;
    logic              alloc_ok;
    logic              rel_ok;
    status_t           fin_status;
    logic [NXT_W-1:0]  fl_next;

    logic              ch_vld [IDX_W+1];
    logic [ADDR_W-1:0] ch_rem [IDX_W+1];
    logic [IDX_W-1:0]  ch_quo [IDX_W+1];

    // handshakes
    assign req.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;

    // register write decode
    always_comb
    begin
        case (cfg.payload.index)
            REG_BASE_ADDRESS: cfg_known = 1'b1;
            REG_BLOCK_BYTES:  cfg_known = 1'b1;
            REG_BLOCK_TOTAL:  cfg_known = 1'b1;
            default:          cfg_known = 1'b0;
        endcase
    end

    assign cfg_hit = cfg_acc && cfg_known && (used_reg == '0);

    // effective block size and block count
    assign wr_size  = cfg.payload.value[SIZE_W-1:0];
    assign size_eff = (wr_size < SIZE_W'(MIN_BLOCK_BYTES)) ? SIZE_W'(MIN_BLOCK_BYTES) : wr_size;
    assign wr_total = cfg.payload.value[TOTAL_W-1:0];

    always_comb
    begin
        if (wr_total == '0)
        begin
            total_eff = NXT_W'(1);
        end
        else if (wr_total > TOTAL_W'(EFF_MAX))
        begin
            total_eff = NXT_W'(EFF_MAX);
        end
        else
        begin
            total_eff = NXT_W'(wr_total);
        end
    end

    // offset of the released address inside the pool
    assign offset_in = req.payload.release_address - base_reg;

    // division chain, one cell per quotient bit, most significant first
    assign ch_vld[0] = req_acc && (req.payload.func == FN_RELEASE);
    assign ch_rem[0] = offset_in;
    assign ch_quo[0] = '0;

    for (genvar g = 0; g < IDX_W; g++)
    begin : g_div
        fbfl_div_cell #(
            .SHIFT (IDX_W - 1 - g),
            .QUO_W (IDX_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (ch_vld[g]),
            .in_rem  (ch_rem[g]),
            .in_quo  (ch_quo[g]),
            .size    (size_reg),
            .out_vld (ch_vld[g+1]),
            .out_rem (ch_rem[g+1]),
            .out_quo (ch_quo[g+1])
        );
    end

    // next-index memory
    fbfl_free_list #(
        .DEPTH (EFF_MAX),
        .IDX_W (IDX_W),
        .NXT_W (NXT_W)
    ) u_free_list (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_hit),
        .rd_idx  (head_reg[IDX_W-1:0]),
        .rd_next (fl_next),
        .wr_en   (rel_ok),
        .wr_idx  (quo_reg),
        .wr_data (head_reg)
    );

    // finish decisions
    assign load_out    = (state_reg == S_FIN) && (!out_vld_reg || rsp.ready);
    assign is_alloc    = (func_reg == FN_ALLOC);
    assign alloc_empty = (head_reg >= total_reg) || (used_reg >= CNT_W'(total_reg));
    assign rel_owned   = (used_reg != '0) && (offset_reg < ADDR_W'(pool_reg)) && remz_reg;
    assign alloc_ok    = load_out && is_alloc && !alloc_empty;
    assign rel_ok      = load_out && !is_alloc && rel_owned;

    always_comb
    begin
        if (is_alloc)
        begin
            fin_status = alloc_empty ? ST_EMPTY : ST_DONE;
        end
        else
        begin
            fin_status = rel_owned ? ST_DONE : ST_NOT_OWNED;
        end
    end

    // item payload, products and division result
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(head_reg[IDX_W-1:0]) * PROD_W'(size_reg);
        pool_reg <= POOL_W'(size_reg) * POOL_W'(total_reg);
        if (req_acc)
        begin
            func_reg   <= req.payload.func;
            offset_reg <= offset_in;
        end
        if (ch_vld[IDX_W])
        begin
            quo_reg  <= ch_quo[IDX_W];
            remz_reg <= (ch_rem[IDX_W] == '0);
        end
    end

    // control state, registers, list head and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            base_reg    <= '0;
            size_reg    <= SIZE_W'(RST_BLOCK_BYTES);
            total_reg   <= NXT_W'(RST_TOTAL);
            head_reg    <= '0;
            used_reg    <= '0;
            out_vld_reg <= 1'b0;
            out_reg     <= '0;
        end
        else
        begin
            // result taken and no new one loaded
            if (rsp.ready && !load_out)
            begin
                out_vld_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_hit)
                    begin
                        case (cfg.payload.index)
                            REG_BASE_ADDRESS: base_reg  <= cfg.payload.value;
                            REG_BLOCK_BYTES:  size_reg  <= size_eff;
                            REG_BLOCK_TOTAL:  total_reg <= total_eff;
                            default:          base_reg  <= base_reg;
                        endcase
                        head_reg <= '0;
                        used_reg <= '0;
                    end
                    else if (req_acc)
                    begin
                        state_reg <= (req.payload.func == FN_RELEASE) ? S_DIV : S_FIN;
                    end
                end
                S_DIV:
                begin
                    if (ch_vld[IDX_W])
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                        if (alloc_ok)
                        begin
                            head_reg <= fl_next;
                            used_reg <= used_reg + CNT_W'(1);
                        end
                        else if (rel_ok)
                        begin
                            head_reg <= NXT_W'(quo_reg);
                            used_reg <= used_reg - CNT_W'(1);
                        end
                        out_vld_reg           <= 1'b1;
                        out_reg.status        <= fin_status;
                        out_reg.block_address <= alloc_ok ?
                            (base_reg + ADDR_W'(prod_reg)) : '0;
                        out_reg.blocks_in_use <= alloc_ok ? (used_reg + CNT_W'(1)) :
                            (rel_ok ? (used_reg - CNT_W'(1)) : used_reg);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid   = out_vld_reg;
    assign rsp.payload = out_reg;

    // checks
    `FBFL_ASSERT_IMP(a_used_cap, 1'b1, used_reg <= CNT_W'(total_reg),
        "blocks in use exceed pool capacity")
    `FBFL_ASSERT_NXT(a_cfg_rebuild, cfg_hit, (head_reg == '0) && (used_reg == '0),
        "register write did not rebuild the free list")
    `FBFL_ASSERT_NXT(a_alloc_count, alloc_ok, used_reg == $past(used_reg) + CNT_W'(1),
        "allocate did not raise the use count by one")
    `FBFL_ASSERT_NXT(a_reject_hold, load_out && (fin_status != ST_DONE),
        $stable(head_reg) && $stable(used_reg), "refused item changed the free list")

endmodule
`default_nettype wire

/* dv/tb_fixed_block_free_list_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_block_free_list_allocator
// drives allocate and release items into the block pool and checks every
// result against an in-bench model of the lifo free list; a short scripted
// run covers the corner cases, then random phases walk through several pool
// settings with random idling on both the request and the result side
// ----------------------------------------------------------------------------
module tb_fixed_block_free_list_allocator;

    import fbfl_pkg::*;

    localparam int POOL_DEPTH  = 64;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 80;
    localparam int GAP_MAX     = 19;

    // index past the register list, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // script row kinds
    localparam bit ROW_ITEM = 1'b0;
    localparam bit ROW_REG  = 1'b1;

    typedef struct packed {
        bit                   kind;
        logic [CFG_IDX_W-1:0] index;
        func_t                func;
        logic [ADDR_W-1:0]    data;
        bit                   typed;
        status_t              status;
        logic [ADDR_W-1:0]    block_address;
        logic [CNT_W-1:0]     blocks_in_use;
    } script_row_t;

    // corner case script, the expected result is filled in where obvious
    localparam int SCRIPT_LEN = 29;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // fresh pool hands out blocks in ascending order
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_ALLOC,   32'h0000_0000, 1'b1, ST_DONE,      32'h00, 7'd1},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_ALLOC,   32'hFFFF_FFFF, 1'b1, ST_DONE,      32'h40, 7'd2},
        // misaligned, past the pool, below the base
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_RELEASE, 32'h0000_0041, 1'b1, ST_NOT_OWNED, 32'h00, 7'd2},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_RELEASE, 32'h0000_1000, 1'b1, ST_NOT_OWNED, 32'h00, 7'd2},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_RELEASE, 32'hFFFF_FFC0, 1'b1, ST_NOT_OWNED, 32'h00, 7'd2},
        // register write while blocks are out is dropped
        '{ROW_REG,  REG_BLOCK_TOTAL,  FN_ALLOC,   32'h0000_0001, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_RELEASE, 32'h0000_0040, 1'b1, ST_DONE,      32'h00, 7'd1},
        // lifo reuse and a double release
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_ALLOC,   32'h0000_0000, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_RELEASE, 32'h0000_0040, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_RELEASE, 32'h0000_0040, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_ALLOC,   32'h1234_5678, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_ALLOC,   32'h0000_0000, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_RELEASE, 32'h0000_0000, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_RELEASE, 32'h0000_0000, 1'b0, ST_DONE,      32'h00, 7'd0},
        // release with nothing in use
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_RELEASE, 32'h0000_0000, 1'b1, ST_NOT_OWNED, 32'h00, 7'd0},
        // one minimum-size block at the top of the address space
        '{ROW_REG,  REG_BASE_ADDRESS, FN_ALLOC,   32'hFFFF_FFF0, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_REG,  REG_BLOCK_BYTES,  FN_ALLOC,   32'h0000_0000, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_REG,  REG_BLOCK_TOTAL,  FN_ALLOC,   32'h0000_0000, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_ALLOC,   32'h0000_0000, 1'b1, ST_DONE,
          32'hFFFF_FFF0, 7'd1},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_ALLOC,   32'h0000_0000, 1'b1, ST_EMPTY,     32'h00, 7'd1},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_RELEASE, 32'hFFFF_FFF8, 1'b1, ST_NOT_OWNED, 32'h00, 7'd1},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_RELEASE, 32'hFFFF_FFF0, 1'b1, ST_DONE,      32'h00, 7'd0},
        // oversized total, spare index, largest block size
        '{ROW_REG,  REG_BLOCK_TOTAL,  FN_ALLOC,   32'h0000_007F, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_REG,  REG_SPARE,        FN_ALLOC,   32'hDEAD_BEEF, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_REG,  REG_BLOCK_BYTES,  FN_ALLOC,   32'hFFFF_FFFF, 1'b0, ST_DONE,      32'h00, 7'd0},
        // second block wraps past the top of the address space
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_ALLOC,   32'h0000_0000, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_ALLOC,   32'h0000_0000, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_RELEASE, 32'h0001_FFEF, 1'b0, ST_DONE,      32'h00, 7'd0},
        '{ROW_ITEM, REG_BASE_ADDRESS, FN_RELEASE, 32'hFFFF_FFF0, 1'b0, ST_DONE,      32'h00, 7'd0}
    };

    logic clk;
    logic rst_n;

    fbfl_chan_if #(.payload_t(req_t)) req_if ();
    fbfl_chan_if #(.payload_t(rsp_t)) rsp_if ();
    fbfl_chan_if #(.payload_t(cfg_t)) cfg_if ();

    fixed_block_free_list_allocator #(
        .MAX_BLOCKS (POOL_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // pool model state and registers
    logic [ADDR_W-1:0]  pool_base;
    logic [SIZE_W-1:0]  pool_bytes;
    logic [TOTAL_W-1:0] pool_total;
    int unsigned        free_top;
    int unsigned        chain [POOL_DEPTH];
    int unsigned        taken_count;

    // results still owed by the block, oldest first
    rsp_t              awaited_results [$];
    // addresses handed out, used to aim releases
    logic [ADDR_W-1:0] handed_out [$];
    logic [ADDR_W-1:0] last_freed;

    int unsigned gap_max;
    int          errors;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(5_000_000);
        $display("[fixed_block_free_list_allocator] ERROR");
        $finish;
    end

    function automatic longint unsigned unit_bytes();
        return (pool_bytes < MIN_BLOCK_BYTES) ? 64'(MIN_BLOCK_BYTES) : 64'(pool_bytes);
    endfunction

    function automatic int unsigned unit_count();
        if (pool_total == 0) return 1;
        if (pool_total > POOL_DEPTH) return POOL_DEPTH;
        return pool_total;
    endfunction

    // free list back to ascending order, nothing in use
    function automatic void rebuild_pool();
        for (int k = 0; k < POOL_DEPTH; k++) chain[k] = k + 1;
        free_top    = 0;
        taken_count = 0;
        handed_out.delete();
    endfunction

    // register write, dropped while any block is out
    function automatic void pool_write(input cfg_t w);
        if (taken_count != 0) return;
        case (w.index)
            REG_BASE_ADDRESS: pool_base  = w.value;
            REG_BLOCK_BYTES:  pool_bytes = w.value[SIZE_W-1:0];
            REG_BLOCK_TOTAL:  pool_total = w.value[TOTAL_W-1:0];
            default:          return;
        endcase
        rebuild_pool();
    endfunction

    // allocate or release one block, returns the result the block owes
    function automatic rsp_t pool_step(input req_t it);
        longint unsigned size;
        longint unsigned offset;
        longint unsigned addr;
        int unsigned     total;
        int unsigned     idx;
        rsp_t            r;
        size            = unit_bytes();
        total           = unit_count();
        r.status        = ST_DONE;
        r.block_address = '0;
        if (it.func == FN_ALLOC)
        begin
            if (free_top >= total || taken_count >= total)
                r.status = ST_EMPTY;
            else
            begin
                addr            = {32'h0, pool_base} + size * free_top;
                r.block_address = addr[ADDR_W-1:0];
                free_top        = chain[free_top];
                taken_count++;
            end
        end
        else
        begin
            // ownership judged on the wrapped offset from the base
            offset = {32'h0, it.release_address - pool_base};
            if (taken_count == 0 || offset >= size * total || offset % size != 0)
                r.status = ST_NOT_OWNED;
            else
            begin
                idx = 32'(offset / size);
                if (idx < POOL_DEPTH)
                begin
                    chain[idx] = free_top;
                    free_top   = idx;
                    taken_count--;
                end
                else
                    r.status = ST_NOT_OWNED;
            end
        end
        r.blocks_in_use = 7'(taken_count);
        return r;
    endfunction

    // send one request item and queue what it should return
    task automatic issue_item(input req_t it, input bit typed, input rsp_t given);
        int unsigned pause;
        int          hit [$];
        rsp_t        want;
        pause = $urandom_range(0, gap_max);
        if (pause != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= it;
        do @(posedge clk); while (!req_if.ready);
        want = pool_step(it);
        awaited_results.push_back(typed ? given : want);
        // keep track of live blocks for later releases
        if (want.status == ST_DONE && it.func == FN_ALLOC)
            handed_out.push_back(want.block_address);
        if (want.status == ST_DONE && it.func == FN_RELEASE)
        begin
            hit = handed_out.find_first_index(a) with (a == it.release_address);
            if (hit.size() != 0) handed_out.delete(hit[0]);
            last_freed = it.release_address;
        end
    endtask

    // stop requests and wait for every owed result
    task automatic settle();
        req_if.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
    endtask

    // register write, valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        cfg_t w;
        w.index = idx;
        w.value = val;
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= w;
        do @(posedge clk); while (!cfg_if.ready);
        pool_write(w);
    endtask

    // result side: random stalls, compare with the oldest expectation
    initial
    begin
        rsp_t        got;
        rsp_t        want;
        int unsigned stall;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, gap_max);
            if (stall != 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
            got = rsp_if.payload;
            if (awaited_results.size() == 0)
            begin
                $error("result with no item outstanding: status %0d address %h in use %0d",
                       got.status, got.block_address, got.blocks_in_use);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.block_address !== want.block_address)
                begin
                    $error("block_address: expected %h, got %h",
                           want.block_address, got.block_address);
                    errors++;
                end
                if (got.blocks_in_use !== want.blocks_in_use)
                begin
                    $error("blocks_in_use: expected %0d, got %0d",
                           want.blocks_in_use, got.blocks_in_use);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        req_t              it;
        rsp_t              given;
        logic [ADDR_W-1:0] base_v;
        logic [ADDR_W-1:0] bytes_v;
        logic [ADDR_W-1:0] total_v;
        int unsigned       alloc_pct;
        int unsigned       pick;
        errors         = 0;
        gap_max        = 0;
        last_freed     = '0;
        pool_base      = '0;
        pool_bytes     = SIZE_W'(RST_BLOCK_BYTES);
        pool_total     = TOTAL_W'(RST_BLOCK_TOTAL);
        rebuild_pool();
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.payload <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scripted corner cases
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (SCRIPT[i].kind == ROW_REG)
            begin
                settle();
                write_reg(SCRIPT[i].index, SCRIPT[i].data);
                if (i + 1 == SCRIPT_LEN || SCRIPT[i + 1].kind != ROW_REG)
                    cfg_if.valid <= 1'b0;
            end
            else
            begin
                it.func               = SCRIPT[i].func;
                it.release_address    = SCRIPT[i].data;
                given.status          = SCRIPT[i].status;
                given.block_address   = SCRIPT[i].block_address;
                given.blocks_in_use   = SCRIPT[i].blocks_in_use;
                issue_item(it, SCRIPT[i].typed, given);
            end
        end

        // random phases, each under its own pool setting
        given = '0;
        for (int p = 0; p < PHASES; p++)
        begin
            gap_max = (p % 3 == 0) ? 0 : GAP_MAX;
            // a write with blocks still out must be dropped
            if (p % 2 == 1 && taken_count != 0)
            begin
                settle();
                write_reg(REG_BLOCK_BYTES, $urandom);
                cfg_if.valid <= 1'b0;
            end
            // hand everything back so the new setting takes
            while (taken_count != 0)
            begin
                it.func            = FN_RELEASE;
                it.release_address = pool_base;
                issue_item(it, 1'b0, given);
            end
            case (p)
                0:
                begin
                    base_v  = $urandom;
                    bytes_v = $urandom_range(8, 64);
                    total_v = POOL_DEPTH;
                end
                1:
                begin
                    base_v  = '0;
                    bytes_v = MIN_BLOCK_BYTES;
                    total_v = 1;
                end
                2:
                begin
                    base_v  = 32'hFFFF_FF00;
                    bytes_v = 32'h0001_0000;
                    total_v = POOL_DEPTH;
                end
                3:
                begin
                    base_v  = $urandom;
                    bytes_v = 32'h0001_FFFF;
                    total_v = TOTAL_MAX;
                end
                4:
                begin
                    base_v  = $urandom;
                    bytes_v = $urandom_range(0, 7);
                    total_v = $urandom_range(1, 8);
                end
                default:
                begin
                    base_v  = $urandom;
                    bytes_v = $urandom;
                    total_v = $urandom;
                end
            endcase
            settle();
            write_reg(REG_BASE_ADDRESS, base_v);
            write_reg(REG_BLOCK_BYTES, bytes_v);
            write_reg(REG_BLOCK_TOTAL, total_v);
            cfg_if.valid <= 1'b0;

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // alternate filling and emptying the pool
                alloc_pct          = ((k / 40) % 2 == 0) ? 80 : 30;
                it.release_address = $urandom;
                if ($urandom_range(0, 99) < alloc_pct)
                    it.func = FN_ALLOC;
                else
                begin
                    it.func = FN_RELEASE;
                    pick    = $urandom_range(0, 99);
                    if (pick < 70 && handed_out.size() != 0)
                        it.release_address = handed_out[$urandom_range(0, handed_out.size() - 1)];
                    else if (pick < 78)
                        it.release_address = last_freed;
                    else if (pick < 86)
                        it.release_address = pool_base
                            + 32'(unit_bytes() * $urandom_range(0, unit_count() - 1))
                            + $urandom_range(1, 32'(unit_bytes() - 1));
                    else if (pick >= 93)
                        it.release_address = pool_base
                            + 32'(unit_bytes() * (unit_count() + $urandom_range(0, 3)));
                end
                issue_item(it, 1'b0, given);
            end
        end

        // drain and let any stray result show up
        settle();
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("[fixed_block_free_list_allocator] OK");
        else
            $display("[fixed_block_free_list_allocator] ERROR");
        $finish;
    end

endmodule
